[design/pit_pkg.sv]
// Package for the presence interval tracker: op codes, register indexes,
// fixed field widths and the store command struct. No dependencies.
`default_nettype none

package pit_pkg;

	localparam int OP_W     = 2;
	localparam int CNT_W    = 8;
	localparam int CAP_W    = 8;
	localparam int GAP_W    = 16;
	localparam int SPAN_W   = 40;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_JOIN  = 2'd0;
	localparam logic [OP_W-1:0] OP_PART  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_SWEEP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN = 2'd2;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 8'd64;
	localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd30;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 40'd0;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_cmd_t;

endpackage

`default_nettype wire

[design/pit_ifs.sv]
// Item channel interfaces for the presence interval tracker.
// Depends on pit_pkg for field widths.
`default_nettype none

interface pit_cmd_if #(
	parameter int TIME_BITS = 40
);
	logic                     valid;
	logic                     ready;
	logic [pit_pkg::OP_W-1:0] op;
	logic [TIME_BITS-1:0]     event_time;

	modport source (output valid, op, event_time, input ready);
	modport sink   (input valid, op, event_time, output ready);
endinterface

interface pit_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      present;
	logic                      is_open;
	logic [pit_pkg::CNT_W-1:0] closed_count;
	logic                      record_empty;

	modport source (output valid, present, is_open, closed_count, record_empty, input ready);
	modport sink   (input valid, present, is_open, closed_count, record_empty, output ready);
endinterface

`default_nettype wire

[design/pit_store.sv]
// Closed interval store: start and end memories, one write and one
// registered read per cycle. Depends on pit_pkg (mem_cmd_t).
`default_nettype none

module pit_store #(
	parameter int INTERVAL_DEPTH = 256,
	parameter int TIME_BITS      = 40,
	parameter int PTR_W          = 8
) (
	input  wire                       clk,
	input  wire pit_pkg::mem_cmd_t    cmd,
	input  wire  [PTR_W-1:0]          rd_addr,
	input  wire  [PTR_W-1:0]          wr_addr,
	input  wire  [TIME_BITS-1:0]      wr_start,
	input  wire  [TIME_BITS-1:0]      wr_end,
	output logic [TIME_BITS-1:0]      rd_start,
	output logic [TIME_BITS-1:0]      rd_end
);
	import pit_pkg::*;

	logic [TIME_BITS-1:0] starts_q [INTERVAL_DEPTH];
	logic [TIME_BITS-1:0] ends_q   [INTERVAL_DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			starts_q[wr_addr] <= wr_start;
			ends_q[wr_addr]   <= wr_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_start <= starts_q[rd_addr];
			rd_end   <= ends_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/pit_eval.sv]
// Per-entry evaluation unit, reused for every entry a walk visits:
// range hit for queries, keep test and start clamp for sweeps.
`default_nettype none

module pit_eval #(
	parameter int TIME_BITS = 40
) (
	input  wire  [TIME_BITS-1:0] ref_time,
	input  wire  [TIME_BITS-1:0] ent_start,
	input  wire  [TIME_BITS-1:0] ent_end,
	output logic                 hit,
	output logic                 keep,
	output logic [TIME_BITS-1:0] clamp_start
);
	logic after_start;
	logic before_end;

	assign after_start = ref_time >= ent_start;
	assign before_end  = ref_time <= ent_end;
	assign hit         = after_start && before_end;
	assign keep        = before_end;
	assign clamp_start = after_start ? ref_time : ent_start;

endmodule

`default_nettype wire

[design/pit_seq.sv]
// Sequencer and record state: open start, ring head and count, walks
// over the store. Depends on pit_pkg; drives pit_store and pit_eval.
`default_nettype none

module pit_seq #(
	parameter int INTERVAL_DEPTH = 256,
	parameter int TIME_BITS      = 40,
	parameter int PTR_W          = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd_valid,
	output logic                         cmd_ready,
	input  wire  [pit_pkg::OP_W-1:0]     cmd_op,
	input  wire  [TIME_BITS-1:0]         cmd_time,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output logic                         rsp_present,
	output logic                         rsp_is_open,
	output logic [pit_pkg::CNT_W-1:0]    rsp_count,
	output logic                         rsp_empty,
	input  wire  [pit_pkg::CAP_W-1:0]    cap_cfg,
	input  wire  [pit_pkg::GAP_W-1:0]    gap_cfg,
	input  wire  [pit_pkg::SPAN_W-1:0]   span_cfg,
	output pit_pkg::mem_cmd_t            mem_cmd,
	output logic [PTR_W-1:0]             rd_addr,
	output logic [PTR_W-1:0]             wr_addr,
	output logic [TIME_BITS-1:0]         wr_start,
	output logic [TIME_BITS-1:0]         wr_end,
	input  wire  [TIME_BITS-1:0]         rd_start,
	input  wire  [TIME_BITS-1:0]         rd_end,
	output logic [TIME_BITS-1:0]         ev_time,
	input  wire                          ev_hit,
	input  wire                          ev_keep,
	input  wire  [TIME_BITS-1:0]         ev_clamp
);
	import pit_pkg::*;

	localparam int HW_CAP = (INTERVAL_DEPTH - 1) < 255 ? (INTERVAL_DEPTH - 1) : 255;
	localparam int SUM_W  = (PTR_W > CNT_W ? PTR_W : CNT_W) + 1;
	localparam int CMP_W  = TIME_BITS > SPAN_W ? TIME_BITS : SPAN_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PART_RD  = 3'd1;
	localparam logic [2:0] S_PART_CHK = 3'd2;
	localparam logic [2:0] S_APPEND   = 3'd3;
	localparam logic [2:0] S_WALK     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
	                                              input logic [CNT_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s >= SUM_W'(INTERVAL_DEPTH))
			s = s - SUM_W'(INTERVAL_DEPTH);
		return s[PTR_W-1:0];
	endfunction

	logic [2:0]           state_q;
	logic [OP_W-1:0]      op_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] end_q;
	logic [TIME_BITS-1:0] open_q;
	logic [PTR_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     kept_q;
	logic                 rd_vld_q;
	logic                 present_q;

	logic [CNT_W-1:0]     cap_now;
	logic [CNT_W-1:0]     cap_keep;
	logic [PTR_W-1:0]     last_addr;
	logic [TIME_BITS:0]   merge_lim;
	logic                 merge_ok;
	logic [CMP_W-1:0]     span_x;
	logic [CMP_W-1:0]     time_x;
	logic                 sweep_on;
	logic                 walk_issue;
	logic                 accept;
	logic                 rsp_load;
	logic                 open_hit;
	logic                 walk_hit;

	assign cmd_ready = state_q == S_IDLE;
	assign accept    = cmd_valid && cmd_ready;
	assign rsp_load  = state_q == S_DONE && (!rsp_valid || rsp_ready);

	assign cap_now   = (cap_cfg == '0 || cap_cfg > CAP_W'(HW_CAP)) ? CNT_W'(HW_CAP) : cap_cfg;
	assign cap_keep  = count_q < cap_now ? count_q : cap_now - CNT_W'(1);
	assign last_addr = ring_add(head_q, count_q - CNT_W'(1));
	assign merge_lim = {1'b0, rd_end} + (TIME_BITS + 1)'(gap_cfg);
	assign merge_ok  = merge_lim >= {1'b0, open_q};
	assign span_x    = CMP_W'(span_cfg);
	assign time_x    = CMP_W'(cmd_time);
	assign sweep_on  = span_cfg != '0 && span_x <= time_x && count_q != '0;
	assign walk_issue = state_q == S_WALK && idx_q < count_q;
	assign open_hit  = open_q != '0 && cmd_time >= open_q;
	assign walk_hit  = rd_vld_q && op_q == OP_QUERY && ev_hit;
	assign ev_time   = t_q;

	always_comb begin
		mem_cmd  = '0;
		rd_addr  = ring_add(head_q, idx_q);
		wr_addr  = last_addr;
		wr_start = rd_start;
		wr_end   = end_q;
		case (state_q)
			S_PART_RD: begin
				mem_cmd.rd_en = 1'b1;
				rd_addr       = last_addr;
			end
			S_PART_CHK: begin
				mem_cmd.wr_en = merge_ok && end_q > rd_end;
			end
			S_APPEND: begin
				mem_cmd.wr_en = 1'b1;
				wr_addr       = ring_add(head_q, count_q);
				wr_start      = open_q;
			end
			S_WALK: begin
				mem_cmd.rd_en = walk_issue;
				mem_cmd.wr_en = op_q == OP_SWEEP && rd_vld_q && ev_keep;
				wr_addr       = ring_add(head_q, kept_q);
				wr_start      = ev_clamp;
				wr_end        = rd_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			open_q    <= '0;
			head_q    <= '0;
			count_q   <= '0;
			rd_vld_q  <= 1'b0;
			present_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						present_q <= cmd_op == OP_QUERY && open_hit;
						case (cmd_op)
							OP_JOIN: begin
								if (open_q == '0)
									open_q <= cmd_time;
								state_q <= S_DONE;
							end
							OP_PART: begin
								if (open_q != '0) begin
									end_q   <= cmd_time < open_q ? open_q : cmd_time;
									state_q <= count_q != '0 ? S_PART_RD : S_APPEND;
								end else begin
									state_q <= S_DONE;
								end
							end
							OP_QUERY: begin
								state_q <= (!open_hit && count_q != '0) ? S_WALK : S_DONE;
							end
							default: begin
								state_q <= sweep_on ? S_WALK : S_DONE;
							end
						endcase
						op_q   <= cmd_op;
						t_q    <= cmd_op == OP_SWEEP ? TIME_BITS'(time_x - span_x) : cmd_time;
						idx_q  <= '0;
						kept_q <= '0;
					end
				end
				S_PART_RD: begin
					state_q <= S_PART_CHK;
				end
				S_PART_CHK: begin
					if (merge_ok) begin
						open_q  <= '0;
						state_q <= S_DONE;
					end else begin
						head_q  <= ring_add(head_q, count_q - cap_keep);
						count_q <= cap_keep;
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					open_q  <= '0;
					state_q <= S_DONE;
				end
				S_WALK: begin
					rd_vld_q <= walk_issue && !walk_hit;
					if (walk_issue)
						idx_q <= idx_q + CNT_W'(1);
					if (rd_vld_q && op_q == OP_SWEEP && ev_keep)
						kept_q <= kept_q + CNT_W'(1);
					if (walk_hit) begin
						present_q <= 1'b1;
						state_q   <= S_DONE;
					end else if (!walk_issue && !rd_vld_q) begin
						if (op_q == OP_SWEEP)
							count_q <= kept_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_present <= present_q;
			rsp_is_open <= open_q != '0;
			rsp_count   <= count_q;
			rsp_empty   <= count_q == '0 && open_q == '0;
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HW_CAP))
		else $error("closed interval count above store capacity");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_cmd.rd_en && mem_cmd.wr_en) |-> rd_addr != wr_addr)
		else $error("store read and write hit the same entry");

	a_kept_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (kept_q <= idx_q && idx_q <= count_q))
		else $error("walk indexes out of order");

	a_rd_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> $past(state_q == S_WALK))
		else $error("walk data flagged outside a walk");

	a_part_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (open_q == '0 && count_q != '0))
		else $error("append left record open or empty");
`endif

endmodule

`default_nettype wire

[design/presence_interval_tracker_core.sv]
// Query and sweep walk the closed intervals through the store's single
// read port, one closed interval per cycle. One item is taken at a time;
// a result may wait in its output register while the next item is
// processed.
// Reset clears the open start, ring pointers and registers to defaults;
// the interval store is not cleared and needs no clearing pass.
`default_nettype none

module presence_interval_tracker_core #(
	parameter int INTERVAL_DEPTH = 256,
	parameter int TIME_BITS      = 40
) (
	input  wire                              clk,
	input  wire                              arst_n,
	pit_cmd_if.sink                          cmd,
	pit_rsp_if.source                        rsp,
	input  wire                              cfg_we,
	input  wire  [pit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [pit_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pit_pkg::*;

	localparam int PTR_W = $clog2(INTERVAL_DEPTH);

	logic [CAP_W-1:0]     cap_q;
	logic [GAP_W-1:0]     gap_q;
	logic [SPAN_W-1:0]    span_q;

	mem_cmd_t             mem_cmd;
	logic [PTR_W-1:0]     rd_addr;
	logic [PTR_W-1:0]     wr_addr;
	logic [TIME_BITS-1:0] wr_start;
	logic [TIME_BITS-1:0] wr_end;
	logic [TIME_BITS-1:0] rd_start;
	logic [TIME_BITS-1:0] rd_end;
	logic [TIME_BITS-1:0] ev_time;
	logic                 ev_hit;
	logic                 ev_keep;
	logic [TIME_BITS-1:0] ev_clamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			gap_q  <= GAP_RESET;
			span_q <= SPAN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAP:  cap_q  <= cfg_data[CAP_W-1:0];
				CFG_GAP:  gap_q  <= cfg_data[GAP_W-1:0];
				CFG_SPAN: span_q <= cfg_data[SPAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pit_seq #(
		.INTERVAL_DEPTH(INTERVAL_DEPTH),
		.TIME_BITS     (TIME_BITS),
		.PTR_W         (PTR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_ready  (cmd.ready),
		.cmd_op     (cmd.op),
		.cmd_time   (cmd.event_time),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_present(rsp.present),
		.rsp_is_open(rsp.is_open),
		.rsp_count  (rsp.closed_count),
		.rsp_empty  (rsp.record_empty),
		.cap_cfg    (cap_q),
		.gap_cfg    (gap_q),
		.span_cfg   (span_q),
		.mem_cmd    (mem_cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_start   (wr_start),
		.wr_end     (wr_end),
		.rd_start   (rd_start),
		.rd_end     (rd_end),
		.ev_time    (ev_time),
		.ev_hit     (ev_hit),
		.ev_keep    (ev_keep),
		.ev_clamp   (ev_clamp)
	);

	pit_store #(
		.INTERVAL_DEPTH(INTERVAL_DEPTH),
		.TIME_BITS     (TIME_BITS),
		.PTR_W         (PTR_W)
	) u_store (
		.clk     (clk),
		.cmd     (mem_cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_start(wr_start),
		.wr_end  (wr_end),
		.rd_start(rd_start),
		.rd_end  (rd_end)
	);

	pit_eval #(
		.TIME_BITS(TIME_BITS)
	) u_eval (
		.ref_time   (ev_time),
		.ent_start  (rd_start),
		.ent_end    (rd_end),
		.hit        (ev_hit),
		.keep       (ev_keep),
		.clamp_start(ev_clamp)
	);

endmodule

`default_nettype wire
